FILE: rtl/stbl_pkg.sv
package stbl_pkg;

   localparam int MAX_RADIUS = 31;
   localparam int MAX_LINE   = 4096;

   localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
   localparam int WIN_AW    = $clog2(WIN_DEPTH);
   localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
   localparam int RP1_W     = $clog2(MAX_RADIUS + 2);
   localparam int SQ_W      = 2 * RP1_W;
   localparam int POS_W     = $clog2(MAX_LINE + MAX_RADIUS);

   localparam int PIX_W  = 16;
   localparam int CH_W   = 6;
   localparam int WS_W   = 17;
   localparam int RS_W   = 11;
   localparam int MUL_W  = 16;
   localparam int SHF_W  = 5;
   localparam int PROD_W = WS_W + MUL_W;
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 16;

   localparam logic [CSR_AW-1:0] REG_RADIUS      = 2'd0;
   localparam logic [CSR_AW-1:0] REG_SCALE_MUL   = 2'd1;
   localparam logic [CSR_AW-1:0] REG_SCALE_SHIFT = 2'd2;

   typedef logic [CH_W-1:0] chan_type;
   typedef chan_type [2:0] chans_type;

   typedef struct packed {
      logic take;
      logic first;
      logic calc_sq;
      logic init_sums;
      logic rd_issue;
      logic update;
      logic mul;
      logic load_out;
      logic last;
   } ctl_cmd_type;

   typedef struct packed {
      logic [RAD_W-1:0] act_radius;
      logic             out_free;
   } dp_sts_type;

   // red, green, blue
   function automatic chans_type split_pixel(input logic [PIX_W-1:0] p);
      chans_type c;
      c[0] = {1'b0, p[15:11]};
      c[1] = p[10:5];
      c[2] = {1'b0, p[4:0]};
      return c;
   endfunction

endpackage

FILE: rtl/stack_blur_rgb565_line.sv
// channel | dir | handshake              | payload
// req     | in  | req_tvalid/req_tready  | req_tdata: pixel_in; req_tlast: line_end
// rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata: pixel_out; rsp_tlast: last_out
// csr     | in  | csr_we                 | csr_addr, csr_wdata: radius, multiplier, shift
//
// Each pixel passes accept, window read or square, sum update, multiply and output
// load (these two only when it yields an output), and step; the first pixel of a line
// takes the square path. A line end adds radius further pushes of the last pixel. A new
// pixel is taken only after the last one's steps. The window is one registered-read memory.
// Reset needs no clearing pass: window entries not yet written in a line read as
// its first pixel. Output waits in a register while rsp_tready is low.
module stack_blur_rgb565_line (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [stbl_pkg::PIX_W-1:0]  req_tdata,   // [15:0] pixel_in
   input  logic                        req_tlast,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [stbl_pkg::PIX_W-1:0]  rsp_tdata,   // [15:0] pixel_out
   output logic                        rsp_tlast,
   input  logic                        csr_we,
   input  logic [stbl_pkg::CSR_AW-1:0] csr_addr,
   input  logic [stbl_pkg::CSR_DW-1:0] csr_wdata
);

   import stbl_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   stbl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .sts        (sts),
      .cmd        (cmd)
   );

   stbl_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: rtl/stbl_ram.sv
module stbl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 63
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: rtl/stbl_datapath.sv
module stbl_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [stbl_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [stbl_pkg::CSR_DW-1:0]  csr_wdata,
   input  logic [stbl_pkg::PIX_W-1:0]   req_tdata,
   input  stbl_pkg::ctl_cmd_type        cmd,
   output stbl_pkg::dp_sts_type         sts,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [stbl_pkg::PIX_W-1:0]   rsp_tdata,
   output logic                         rsp_tlast
);

   import stbl_pkg::*;

   logic [RAD_W-1:0]  radius_ff, radius_in;
   logic [MUL_W-1:0]  scale_mul_ff, scale_mul_in;
   logic [SHF_W-1:0]  scale_shift_ff, scale_shift_in;
   logic [PIX_W-1:0]  pix_ff, pix_in;
   logic [PIX_W-1:0]  first_px_ff, first_px_in;
   logic [RAD_W-1:0]  act_r_ff, act_r_in;
   logic [WIN_AW-1:0] depth_ff, depth_in;
   logic [WIN_AW-1:0] wp_ff, wp_in;
   logic [WIN_AW-1:0] fill_ff, fill_in;
   logic [WIN_AW-1:0] mid_ff, mid_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [WS_W-1:0]   ws_ff [3];
   logic [WS_W-1:0]   ws_in [3];
   logic [RS_W-1:0]   is_ff [3];
   logic [RS_W-1:0]   is_in [3];
   logic [RS_W-1:0]   os_ff [3];
   logic [RS_W-1:0]   os_in [3];
   logic [PROD_W-1:0] prod_ff [3];
   logic [PROD_W-1:0] prod_in [3];
   logic [PIX_W-1:0]  out_pix_ff, out_pix_in;
   logic              out_last_ff, out_last_in;
   logic              out_vld_ff, out_vld_in;

   logic [PIX_W-1:0]  rd_a, rd_b;
   logic [PIX_W-1:0]  lv_px, md_px;
   chans_type         x_ch, lv_ch, md_ch;
   logic [RAD_W-1:0]  r_sat;
   logic [RP1_W-1:0]  rp1;
   logic [WIN_AW:0]   mid_sum;
   logic [WIN_AW:0]   wp_nx;
   logic [PROD_W-1:0] sh [3];

   stbl_ram #(
      .WIDTH(PIX_W),
      .DEPTH(WIN_DEPTH)
   ) u_win (
      .clock     (clock),
      .wr_en     (cmd.update),
      .wr_addr   (wp_ff),
      .wr_data   (pix_ff),
      .rd_addr_a (wp_ff),
      .rd_addr_b (mid_in),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   always_comb begin
      radius_in      = radius_ff;
      scale_mul_in   = scale_mul_ff;
      scale_shift_in = scale_shift_ff;
      pix_in         = pix_ff;
      first_px_in    = first_px_ff;
      act_r_in       = act_r_ff;
      depth_in       = depth_ff;
      wp_in          = wp_ff;
      fill_in        = fill_ff;
      mid_in         = mid_ff;
      sq_in          = sq_ff;
      out_pix_in     = out_pix_ff;
      out_last_in    = out_last_ff;
      out_vld_in     = out_vld_ff;
      for (int i = 0; i < 3; i++) begin
         ws_in[i]   = ws_ff[i];
         is_in[i]   = is_ff[i];
         os_in[i]   = os_ff[i];
         prod_in[i] = prod_ff[i];
      end

      if (csr_we) begin
         unique case (csr_addr)
            REG_RADIUS:      radius_in      = csr_wdata[RAD_W-1:0];
            REG_SCALE_MUL:   scale_mul_in   = csr_wdata[MUL_W-1:0];
            REG_SCALE_SHIFT: scale_shift_in = csr_wdata[SHF_W-1:0];
            default: ;
         endcase
      end

      r_sat = (radius_ff > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_ff;
      rp1   = RP1_W'(act_r_ff) + RP1_W'(1);
      x_ch  = split_pixel(pix_ff);

      if (cmd.take) begin
         pix_in = req_tdata;
      end
      if (cmd.first) begin
         first_px_in = req_tdata;
         act_r_in    = r_sat;
         depth_in    = WIN_AW'({r_sat, 1'b1});
         wp_in       = '0;
         fill_in     = '0;
      end

      if (cmd.calc_sq) begin
         sq_in = SQ_W'(rp1) * SQ_W'(rp1);
      end

      if (cmd.init_sums) begin
         for (int i = 0; i < 3; i++) begin
            ws_in[i] = WS_W'(x_ch[i]) * WS_W'(sq_ff);
            os_in[i] = RS_W'(x_ch[i]) * RS_W'(rp1);
            is_in[i] = RS_W'(x_ch[i]) * RS_W'(act_r_ff);
         end
      end

      // middle tap: pointer plus r+1, modulo the window depth
      mid_sum = {1'b0, wp_ff} + (WIN_AW+1)'(act_r_ff) + (WIN_AW+1)'(1);
      if (cmd.rd_issue) begin
         if (mid_sum >= {1'b0, depth_ff}) begin
            mid_in = WIN_AW'(mid_sum - {1'b0, depth_ff});
         end else begin
            mid_in = WIN_AW'(mid_sum);
         end
      end

      // entries not yet written in this line read as the line's first pixel
      lv_px = (wp_ff < fill_ff) ? rd_a : first_px_ff;
      if (act_r_ff == '0) begin
         md_px = pix_ff;
      end else begin
         md_px = (mid_ff < fill_ff) ? rd_b : first_px_ff;
      end
      lv_ch = split_pixel(lv_px);
      md_ch = split_pixel(md_px);
      wp_nx = {1'b0, wp_ff} + (WIN_AW+1)'(1);

      if (cmd.update) begin
         for (int i = 0; i < 3; i++) begin
            ws_in[i] = ws_ff[i] - WS_W'(os_ff[i]) + WS_W'(is_ff[i]) + WS_W'(x_ch[i]);
            os_in[i] = os_ff[i] - RS_W'(lv_ch[i]) + RS_W'(md_ch[i]);
            is_in[i] = is_ff[i] - RS_W'(md_ch[i]) + RS_W'(x_ch[i]);
         end
         wp_in = (wp_nx >= {1'b0, depth_ff}) ? '0 : WIN_AW'(wp_nx);
         if (fill_ff < WIN_AW'(WIN_DEPTH)) begin
            fill_in = fill_ff + WIN_AW'(1);
         end
      end

      if (cmd.mul) begin
         for (int i = 0; i < 3; i++) begin
            prod_in[i] = PROD_W'(ws_ff[i]) * PROD_W'(scale_mul_ff);
         end
      end

      for (int i = 0; i < 3; i++) begin
         sh[i] = prod_ff[i] >> scale_shift_ff;
      end

      if (cmd.load_out) begin
         out_pix_in  = {sh[0][4:0], sh[1][5:0], sh[2][4:0]};
         out_last_in = cmd.last;
         out_vld_in  = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff      <= RAD_W'(1);
         scale_mul_ff   <= MUL_W'(1);
         scale_shift_ff <= '0;
         act_r_ff       <= '0;
         depth_ff       <= WIN_AW'(1);
         wp_ff          <= '0;
         fill_ff        <= '0;
         out_vld_ff     <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            ws_ff[i] <= '0;
            is_ff[i] <= '0;
            os_ff[i] <= '0;
         end
      end else begin
         radius_ff      <= radius_in;
         scale_mul_ff   <= scale_mul_in;
         scale_shift_ff <= scale_shift_in;
         act_r_ff       <= act_r_in;
         depth_ff       <= depth_in;
         wp_ff          <= wp_in;
         fill_ff        <= fill_in;
         out_vld_ff     <= out_vld_in;
         for (int i = 0; i < 3; i++) begin
            ws_ff[i] <= ws_in[i];
            is_ff[i] <= is_in[i];
            os_ff[i] <= os_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      first_px_ff <= first_px_in;
      mid_ff      <= mid_in;
      sq_ff       <= sq_in;
      out_pix_ff  <= out_pix_in;
      out_last_ff <= out_last_in;
      for (int i = 0; i < 3; i++) begin
         prod_ff[i] <= prod_in[i];
      end
   end

   assign sts.act_radius = act_r_ff;
   assign sts.out_free   = !out_vld_ff || rsp_tready;

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_pix_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   a_wp_in_window: assert property (@(posedge clock) disable iff (reset)
      wp_ff < depth_ff)
      else $error("window pointer beyond window depth");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= WIN_AW'(WIN_DEPTH))
      else $error("fill count beyond store depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!out_vld_ff || rsp_tready))
      else $error("output register overwritten while held");

   a_mid_in_window: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_issue |=> (mid_ff < depth_ff))
      else $error("middle tap beyond window depth");
`endif

endmodule

FILE: rtl/stbl_ctrl.sv
module stbl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tlast,
   input  stbl_pkg::dp_sts_type  sts,
   output stbl_pkg::ctl_cmd_type cmd
);

   import stbl_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQ   = 3'd1;
   localparam logic [2:0] ST_INIT = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_UPD  = 3'd4;
   localparam logic [2:0] ST_MUL  = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;
   localparam logic [2:0] ST_NEXT = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [RAD_W-1:0] drain_ff, drain_in;
   logic             end_ff, end_in;

   logic emit;
   logic drain_done;

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      drain_in = drain_ff;
      end_in   = end_ff;
      cmd      = '0;

      req_tready = (state_ff == ST_IDLE);
      emit       = (pos_ff >= POS_W'(sts.act_radius));
      drain_done = (drain_ff == sts.act_radius);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.take = 1'b1;
               end_in   = req_tlast;
               drain_in = '0;
               if (pos_ff == '0) begin
                  cmd.first = 1'b1;
                  state_in  = ST_SQ;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_SQ: begin
            cmd.calc_sq = 1'b1;
            state_in    = ST_INIT;
         end
         ST_INIT: begin
            cmd.init_sums = 1'b1;
            state_in      = emit ? ST_MUL : ST_NEXT;
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_UPD;
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in   = emit ? ST_MUL : ST_NEXT;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               cmd.last     = end_ff && drain_done;
               state_in     = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (!end_ff) begin
               if (pos_ff < POS_W'(MAX_LINE - 1)) begin
                  pos_in = pos_ff + POS_W'(1);
               end
               state_in = ST_IDLE;
            end else if (drain_done) begin
               pos_in   = '0;
               state_in = ST_IDLE;
            end else begin
               // line end: push the last pixel again
               pos_in   = pos_ff + POS_W'(1);
               drain_in = drain_ff + RAD_W'(1);
               state_in = ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         drain_ff <= '0;
         end_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         drain_ff <= drain_in;
         end_ff   <= end_in;
      end
   end

`ifndef SYNTHESIS
   a_drain_on_end: assert property (@(posedge clock) disable iff (reset)
      (drain_ff != '0) |-> end_ff)
      else $error("drain count running without line end");

   a_drain_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (drain_ff <= sts.act_radius))
      else $error("drain count beyond radius");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff < POS_W'(MAX_LINE + MAX_RADIUS))
      else $error("line position out of range");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && cmd.last) |=> ##1 (pos_ff == '0))
      else $error("final output did not close the line");
`endif

endmodule

FILE: tb/tb_stack_blur_rgb565_line.sv
`timescale 1ns / 1ps

module tb_stack_blur_rgb565_line;

   import stbl_pkg::*;

   localparam logic [CSR_AW-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } blurred_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [PIX_W-1:0] req_tdata;
   logic req_tlast;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [PIX_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_we;
   logic [CSR_AW-1:0] csr_addr;
   logic [CSR_DW-1:0] csr_wdata;

   int unsigned req_idle_pct;
   int unsigned rsp_stall_pct;
   int unsigned error_count;

   // blur predictor state
   logic [4:0]        cfg_radius;
   logic [MUL_W-1:0]  cfg_mul;
   logic [SHF_W-1:0]  cfg_shift;
   logic [PIX_W-1:0]  win_mem [WIN_DEPTH];
   logic [WS_W-1:0]   wsum [3];
   logic [RS_W-1:0]   isum [3];
   logic [RS_W-1:0]   osum [3];
   int unsigned       wptr;
   int unsigned       line_pos;
   int unsigned       act_rad;
   blurred_type       blurred_q [$];
   blurred_type       got;
   blurred_type       want;

   stack_blur_rgb565_line DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic chans_type to_channels(input logic [PIX_W-1:0] p);
      chans_type c;
      c[0] = p[15:11];
      c[1] = p[10:5];
      c[2] = p[4:0];
      return c;
   endfunction

   function automatic logic [PIX_W-1:0] scaled_pixel();
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] v [3];
      for (int i = 0; i < 3; i++) begin
         prod = wsum[i] * cfg_mul;
         v[i] = prod >> cfg_shift;
      end
      return {v[0][4:0], v[1][5:0], v[2][4:0]};
   endfunction

   function automatic void queue_blurred(input logic last);
      blurred_type b;
      b.pixel = scaled_pixel();
      b.last = last;
      blurred_q.push_back(b);
   endfunction

   function automatic void window_push(input logic [PIX_W-1:0] p);
      int unsigned depth;
      int unsigned mid;
      chans_type x, lv, md;
      depth = 2 * act_rad + 1;
      lv = to_channels(win_mem[wptr]);
      win_mem[wptr] = p;
      mid = wptr + act_rad + 1;
      if (mid >= depth) mid -= depth;
      md = to_channels(win_mem[mid]);
      x = to_channels(p);
      for (int i = 0; i < 3; i++) begin
         wsum[i] = wsum[i] - osum[i] + isum[i] + x[i];
         osum[i] = osum[i] - lv[i] + md[i];
         isum[i] = isum[i] - md[i] + x[i];
      end
      wptr++;
      if (wptr >= depth) wptr = 0;
   endfunction

   function automatic void window_fill(input logic [PIX_W-1:0] p);
      int unsigned r;
      chans_type x;
      r = (cfg_radius > MAX_RADIUS) ? MAX_RADIUS : cfg_radius;
      act_rad = r;
      for (int i = 0; i < 2 * r + 1; i++) win_mem[i] = p;
      wptr = 0;
      x = to_channels(p);
      for (int i = 0; i < 3; i++) begin
         wsum[i] = x[i] * (r + 1) * (r + 1);
         osum[i] = x[i] * (r + 1);
         isum[i] = x[i] * r;
      end
   endfunction

   function automatic void predict_blur(input logic [PIX_W-1:0] p, input logic eol);
      int unsigned pos;
      int unsigned r;
      pos = line_pos;
      if (pos == 0) window_fill(p);
      else window_push(p);
      r = act_rad;
      if (!eol) begin
         if (pos >= r) queue_blurred(1'b0);
         if (line_pos < MAX_LINE - 1) line_pos++;
      end else begin
         if (pos >= r) queue_blurred(r == 0);
         for (int j = 1; j <= r; j++) begin
            window_push(p);
            if (pos + j >= r) queue_blurred(j == r);
         end
         line_pos = 0;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pixel = rsp_tdata;
         got.last = rsp_tlast;
         if (blurred_q.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, actual %h last %b",
                     $time, got.pixel, got.last);
            error_count++;
         end else begin
            want = blurred_q.pop_front();
            if (got.pixel !== want.pixel || got.last !== want.last) begin
               $display("%0t: expected pixel %h last %b, actual pixel %h last %b",
                        $time, want.pixel, want.last, got.pixel, got.last);
               error_count++;
            end
         end
      end
   end

   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic eol);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      req_tlast <= eol;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_blur(pix, eol);
   endtask

   task automatic send_random_line(input int unsigned len);
      for (int unsigned i = 0; i < len; i++) send_pixel(16'($urandom), i == len - 1);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (blurred_q.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic write_regs(input logic [4:0] rad, input logic [MUL_W-1:0] mul,
                             input logic [SHF_W-1:0] shf);
      csr_we <= 1'b1;
      csr_addr <= REG_RADIUS;
      csr_wdata <= {11'($urandom), rad};
      @(posedge clock);
      cfg_radius = rad;
      csr_addr <= REG_SCALE_MUL;
      csr_wdata <= mul;
      @(posedge clock);
      cfg_mul = mul;
      csr_addr <= REG_SCALE_SHIFT;
      csr_wdata <= {11'($urandom), shf};
      @(posedge clock);
      cfg_shift = shf;
      csr_addr <= REG_UNUSED;
      csr_wdata <= 16'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_idling(input int unsigned req_pct, input int unsigned rsp_pct);
      req_idle_pct = req_pct;
      rsp_stall_pct = rsp_pct;
   endtask

   task automatic test_default_registers();
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'hF800, 1'b0);
      send_pixel(16'h07E0, 1'b0);
      send_pixel(16'h001F, 1'b1);
      send_pixel(16'hFFFF, 1'b1);
      wait_idle();
   endtask

   task automatic test_radius_extremes();
      write_regs(5'd0, 16'd1, 5'd0);
      send_pixel(16'hA5A5, 1'b0);
      send_pixel(16'h5A5A, 1'b0);
      send_pixel(16'hFFFF, 1'b1);
      wait_idle();
      // short line against the largest window
      write_regs(5'd31, 16'd1, 5'd10);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'h1234, 1'b1);
      send_pixel(16'hFFFF, 1'b1);
      send_random_line(40);
      wait_idle();
   endtask

   task automatic test_radius_change_mid_line();
      write_regs(5'd3, 16'd1, 5'd4);
      for (int i = 0; i < 5; i++) send_pixel(16'($urandom), 1'b0);
      wait_idle();
      // new radius only applies from the next line
      write_regs(5'd7, 16'd1, 5'd6);
      send_random_line(5);
      send_random_line(10);
      wait_idle();
   endtask

   task automatic test_scale_extremes();
      write_regs(5'd1, 16'd0, 5'd0);
      send_random_line(3);
      wait_idle();
      write_regs(5'd1, 16'hFFFF, 5'd0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h8410, 1'b1);
      wait_idle();
      write_regs(5'd1, 16'hFFFF, 5'd31);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'hFFFF, 1'b1);
      wait_idle();
      write_regs(5'd1, 16'hFFFF, 5'd16);
      send_random_line(4);
      wait_idle();
   endtask

   task automatic test_random_lines(input int unsigned req_pct, input int unsigned rsp_pct);
      int unsigned sent;
      int unsigned rad;
      int unsigned len;
      logic [MUL_W-1:0] mul;
      logic [SHF_W-1:0] shf;
      set_idling(req_pct, rsp_pct);
      sent = 0;
      while (sent < 40) begin
         case ($urandom_range(7))
            0: rad = 0;
            1: rad = 31;
            default: rad = $urandom_range(1, 12);
         endcase
         if ($urandom_range(1)) begin
            mul = 16'(65535 / ((rad + 1) * (rad + 1)));
            shf = 5'd16;
         end else begin
            mul = 16'($urandom);
            shf = 5'($urandom_range(31));
         end
         write_regs(5'(rad), mul, shf);
         repeat ($urandom_range(1, 3)) begin
            len = $urandom_range(1, 30);
            send_random_line(len);
            sent += len;
         end
         wait_idle();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_addr = REG_RADIUS;
      csr_wdata = '0;
      error_count = 0;
      cfg_radius = 5'd1;
      cfg_mul = 16'd1;
      cfg_shift = 5'd0;
      for (int i = 0; i < WIN_DEPTH; i++) win_mem[i] = '0;
      for (int i = 0; i < 3; i++) begin
         wsum[i] = '0;
         isum[i] = '0;
         osum[i] = '0;
      end
      wptr = 0;
      line_pos = 0;
      act_rad = 0;
      set_idling(0, 0);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_registers();
      test_radius_extremes();
      test_radius_change_mid_line();
      test_scale_extremes();
      test_random_lines(0, 0);
      test_random_lines(70, 0);
      test_random_lines(0, 70);
      test_random_lines(29, 29);

      set_idling(0, 0);
      req_tvalid <= 1'b0;
      while (blurred_q.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

FILE: files.f
rtl/stbl_pkg.sv
rtl/stbl_ram.sv
rtl/stbl_datapath.sv
rtl/stbl_ctrl.sv
rtl/stack_blur_rgb565_line.sv
tb/tb_stack_blur_rgb565_line.sv
